/* rtl/core/next_smooth_size_search_macros.svh */
// assertion macros for the padded length search
`ifndef NEXT_SMOOTH_SIZE_SEARCH_MACROS_SVH
`define NEXT_SMOOTH_SIZE_SEARCH_MACROS_SVH

// condition holds at every rising clock edge outside reset
`define NSS_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define NSS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define NSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/nss_pkg.sv */
// shared types and constants for the padded length search
`default_nettype none

package nss_pkg;

    localparam int unsigned DEF_SIZE_BITS = 24;

    typedef enum logic [1:0] {
        FACTOR_2,
        FACTOR_3,
        FACTOR_5,
        FACTOR_7
    } factor_t;

    function automatic logic [2:0] factor_value(input factor_t factor);
        logic [2:0] value;
        unique case (factor)
            FACTOR_2: value = 3'd2;
            FACTOR_3: value = 3'd3;
            FACTOR_5: value = 3'd5;
            FACTOR_7: value = 3'd7;
            default:  value = 3'd7;
        endcase
        return value;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/nss_step_unit.sv */
// shared step unit: multiply by a small prime and compare with the current best
`default_nettype none

module nss_step_unit #(
    parameter int unsigned LEN_BITS = nss_pkg::DEF_SIZE_BITS + 1
) (
    input  wire logic [LEN_BITS-1:0] base,
    input  wire nss_pkg::factor_t    factor,
    input  wire logic [LEN_BITS-1:0] bound,
    output logic [LEN_BITS-1:0]      prod,
    output logic                     below
);

    logic [LEN_BITS+2:0] prod_wide;
    logic [2:0]          factor_val;

    assign factor_val = nss_pkg::factor_value(factor);
    assign prod_wide  = {3'b000, base} * {{LEN_BITS{1'b0}}, factor_val};
    assign below      = prod_wide < {3'b000, bound};
    assign prod       = prod_wide[LEN_BITS-1:0];

endmodule

`default_nettype wire

/* rtl/core/next_smooth_size_search.sv */
// the search runs in steps, a step being one candidate product or one exhausted
// factor level; the result is registered in ST_DONE
// throughput: one item at a time, the next item is taken once the result is registered
// the shared multiply-by-prime and compare unit sets the rate, one step per cycle
// reset: asynchronous, clears the sequencer and the result valid, no memory to clear
`default_nettype none

module next_smooth_size_search #(
    parameter int unsigned SIZE_BITS = nss_pkg::DEF_SIZE_BITS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_ready,
    input  wire logic [SIZE_BITS:0]   min_length,
    input  wire logic                 even_only,
    output logic                      rsp_valid,
    input  wire logic                 rsp_ready,
    output logic [SIZE_BITS:0]        padded_length
);

    `include "next_smooth_size_search_macros.svh"

    localparam int unsigned LEN_BITS = SIZE_BITS + 1;
    localparam logic [LEN_BITS-1:0] LEN_MAX = {1'b1, {SIZE_BITS{1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_P7,
        ST_P5,
        ST_P3,
        ST_P2,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [LEN_BITS-1:0] need_reg, need_next;
    logic [LEN_BITS-1:0] best_reg, best_next;
    logic [LEN_BITS-1:0] p2_reg, p2_next;
    logic [LEN_BITS-1:0] p3_reg, p3_next;
    logic [LEN_BITS-1:0] p5_reg, p5_next;
    logic [LEN_BITS-1:0] p7_reg, p7_next;
    logic [LEN_BITS-1:0] padded_length_reg, padded_length_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic [LEN_BITS-1:0] step_base;
    nss_pkg::factor_t    step_factor;
    logic [LEN_BITS-1:0] step_prod;
    logic                step_below;
    logic [LEN_BITS-1:0] start_val;
    logic [LEN_BITS-1:0] need_clamped;

    // operand select for the shared unit
    always_comb
    begin
        unique case (state_reg)
            ST_P7:
            begin
                step_base   = p7_reg;
                step_factor = nss_pkg::FACTOR_7;
            end
            ST_P5:
            begin
                step_base   = p5_reg;
                step_factor = nss_pkg::FACTOR_5;
            end
            ST_P3:
            begin
                step_base   = p3_reg;
                step_factor = nss_pkg::FACTOR_3;
            end
            ST_P2:
            begin
                step_base   = p2_reg;
                step_factor = nss_pkg::FACTOR_2;
            end
            default:
            begin
                step_base   = p7_reg;
                step_factor = nss_pkg::FACTOR_7;
            end
        endcase
    end

    nss_step_unit #(
        .LEN_BITS (LEN_BITS)
    ) u_step (
        .base   (step_base),
        .factor (step_factor),
        .bound  (best_reg),
        .prod   (step_prod),
        .below  (step_below)
    );

    // zero treated as one, above range clamped
    always_comb
    begin
        priority if (min_length == '0)
            need_clamped = LEN_BITS'(1);
        else if (min_length > LEN_MAX)
            need_clamped = LEN_MAX;
        else
            need_clamped = min_length;
    end

    assign start_val = even_only ? LEN_BITS'(2) : LEN_BITS'(1);

    always_comb
    begin
        state_next         = state_reg;
        need_next          = need_reg;
        best_next          = best_reg;
        p2_next            = p2_reg;
        p3_next            = p3_reg;
        p5_next            = p5_reg;
        p7_next            = p7_reg;
        padded_length_next = padded_length_reg;
        rsp_valid_next     = rsp_valid_reg && !rsp_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    need_next  = need_clamped;
                    best_next  = LEN_MAX;
                    p2_next    = start_val;
                    p3_next    = start_val;
                    p5_next    = start_val;
                    p7_next    = start_val;
                    state_next = ST_P7;
                end
            end
            ST_P7:
            begin
                if (p7_reg >= need_reg)
                begin
                    best_next  = p7_reg;
                    state_next = ST_P5;
                end
                else if (step_below)
                begin
                    p7_next = step_prod;
                end
                else
                begin
                    state_next = ST_P5;
                end
            end
            ST_P5:
            begin
                if (step_below)
                begin
                    p5_next    = step_prod;
                    p7_next    = step_prod;
                    state_next = ST_P7;
                end
                else
                begin
                    state_next = ST_P3;
                end
            end
            ST_P3:
            begin
                if (step_below)
                begin
                    p3_next    = step_prod;
                    p5_next    = step_prod;
                    p7_next    = step_prod;
                    state_next = ST_P7;
                end
                else
                begin
                    state_next = ST_P2;
                end
            end
            ST_P2:
            begin
                if (step_below)
                begin
                    p2_next    = step_prod;
                    p3_next    = step_prod;
                    p5_next    = step_prod;
                    p7_next    = step_prod;
                    state_next = ST_P7;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    padded_length_next = best_reg;
                    rsp_valid_next     = 1'b1;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            need_reg          <= '0;
            best_reg          <= '0;
            p2_reg            <= '0;
            p3_reg            <= '0;
            p5_reg            <= '0;
            p7_reg            <= '0;
            padded_length_reg <= '0;
            rsp_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            need_reg          <= need_next;
            best_reg          <= best_next;
            p2_reg            <= p2_next;
            p3_reg            <= p3_next;
            p5_reg            <= p5_next;
            p7_reg            <= p7_next;
            padded_length_reg <= padded_length_next;
            rsp_valid_reg     <= rsp_valid_next;
        end
    end

    assign req_ready     = (state_reg == ST_IDLE);
    assign rsp_valid     = rsp_valid_reg;
    assign padded_length = padded_length_reg;

    `NSS_ASSERT_NEXT(a_accept_starts, req_valid && req_ready, state_reg == ST_P7, "accepted item did not start the search")
    `NSS_ASSERT_IMPL(a_inner_below_best, state_reg == ST_P7, p7_reg < best_reg, "inner candidate not below best")
    `NSS_ASSERT_IMPL(a_best_in_range, state_reg != ST_IDLE, best_reg <= LEN_MAX && best_reg != '0, "best out of range")
    `NSS_ASSERT_IMPL(a_loop_order, state_reg != ST_IDLE, p2_reg <= p3_reg && p3_reg <= p5_reg && p5_reg <= p7_reg, "loop products out of order")
    `NSS_ASSERT_IMPL(a_result_covers_need, state_reg == ST_DONE, best_reg >= need_reg, "result below requested length")

endmodule

`default_nettype wire
